// File: rtl/crv_pkg.sv
// Shared constants, types and delay base tables for the comb/all-pass reverb.
package crv_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COMB_SLOT      = 4096;
  localparam int ALLPASS_SLOT   = 1024;
  localparam int PREDELAY_DEPTH = 4096;

  localparam int NUM_COMB  = 8;
  localparam int NUM_AP    = 4;
  localparam int COEF_W    = 16;
  localparam int PLEN_W    = 12;
  localparam int CFG_IDX_W = 3;
  localparam int BASE_W    = 11;
  // scaled length before clamping: base * (1.5 max) stays below 4096
  localparam int LEN_RAW_W = 12;
  localparam int MUL_B_W   = COEF_W + 1;

  localparam logic [COEF_W-1:0] ROOM_RST = 16'd32768;
  localparam logic [COEF_W-1:0] FB_RST   = 16'd58982;
  localparam logic [COEF_W-1:0] DAMP_RST = 16'd32768;
  localparam logic [PLEN_W-1:0] PLEN_RST = 12'd0;
  localparam logic [COEF_W-1:0] WET_RST  = 16'd21845;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOM = 3'd0,
    CFG_FB   = 3'd1,
    CFG_DAMP = 3'd2,
    CFG_PLEN = 3'd3,
    CFG_WET  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRE,
    ST_C_LEN,
    ST_C_READ,
    ST_C_DAMP,
    ST_C_FB,
    ST_C_WRITE,
    ST_A_LEN,
    ST_A_WRITE,
    ST_MIX_WET,
    ST_MIX_DRY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic en;   // update accumulator
    logic clr;  // start from zero instead of accumulating
    logic rnd;  // add the half-LSB rounding constant of a Q0.16 product
  } mac_ctl_t;

  function automatic logic [BASE_W-1:0] comb_base(input logic [2:0] k);
    logic [BASE_W-1:0] b;
    case (k)
      3'd0:    b = 11'd1116;
      3'd1:    b = 11'd1188;
      3'd2:    b = 11'd1277;
      3'd3:    b = 11'd1356;
      3'd4:    b = 11'd1422;
      3'd5:    b = 11'd1491;
      3'd6:    b = 11'd1557;
      3'd7:    b = 11'd1617;
      default: b = 11'd1116;
    endcase
    return b;
  endfunction

  function automatic logic [BASE_W-1:0] ap_base(input logic [1:0] k);
    logic [BASE_W-1:0] b;
    case (k)
      2'd0:    b = 11'd556;
      2'd1:    b = 11'd441;
      2'd2:    b = 11'd341;
      2'd3:    b = 11'd225;
      default: b = 11'd556;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/crv_mac.sv
// Shared multiply-accumulate unit: signed sample times unsigned Q1.16 coefficient.
module crv_mac #(
  parameter int SAMPLE_BITS = crv_pkg::SAMPLE_BITS,
  parameter int ACC_W       = crv_pkg::SAMPLE_BITS + 20
) (
  input  logic                           clk_i,
  input  crv_pkg::mac_ctl_t              ctl_i,
  input  logic signed [SAMPLE_BITS-1:0]  a_i,
  input  logic [crv_pkg::MUL_B_W-1:0]    b_i,
  output logic signed [ACC_W-1:0]        acc_o
);

  localparam int PROD_W = SAMPLE_BITS + crv_pkg::MUL_B_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_d, acc_q, base_v, rnd_v;

  assign prod   = PROD_W'(a_i) * PROD_W'($signed({1'b0, b_i}));
  assign base_v = ctl_i.clr ? '0 : acc_q;
  assign rnd_v  = ctl_i.rnd ? ACC_W'(32768) : '0;
  assign acc_d  = base_v + ACC_W'(prod) + rnd_v;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: rtl/comb_allpass_reverb_unit.sv
// Top level of the comb/all-pass reverb: sequencer, delay memories and datapath.
//
// Input items (sample_in_i) arrive on in_valid_i/in_ready_o, one result per item
// leaves on out_valid_o/out_ready_i as sample_out_o. Registers are written over
// the cfg_* channel (index, data), which is always ready; write only while idle.
// One shared multiply-accumulate unit serves the comb, all-pass and mix steps
// under a sequencer that runs pre-delay, then each of the 8 comb lines (length,
// read, damp, feedback, write), each of the 4 all-pass stages (length, write)
// and the dry/wet mix (wet, dry, done). in_ready_o is low from acceptance until
// the result is loaded, so no new item is taken before the last one is through.
// The result sits in an output register, so the next item is taken while it
// waits; if the receiver still stalls when the following result is done, the
// sequencer holds in its final step until the output register frees up.
// After reset a clearing pass zeroes all delay memories, one address per cycle
// over max(8*COMB_SLOT, 4*ALLPASS_SLOT, PREDELAY_DEPTH) addresses (32768 with the
// defaults); no item is accepted before it ends, configuration writes are.
module comb_allpass_reverb_unit #(
  parameter int SAMPLE_BITS    = crv_pkg::SAMPLE_BITS,
  parameter int COMB_SLOT      = crv_pkg::COMB_SLOT,
  parameter int ALLPASS_SLOT   = crv_pkg::ALLPASS_SLOT,
  parameter int PREDELAY_DEPTH = crv_pkg::PREDELAY_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [crv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [crv_pkg::COEF_W-1:0]        cfg_data_i
);

  localparam int NC    = crv_pkg::NUM_COMB;
  localparam int NA    = crv_pkg::NUM_AP;
  localparam int CP_W  = $clog2(COMB_SLOT);
  localparam int CL_W  = $clog2(COMB_SLOT + 1);
  localparam int CM_N  = NC * COMB_SLOT;
  localparam int CM_W  = $clog2(CM_N);
  localparam int AP_W  = $clog2(ALLPASS_SLOT);
  localparam int AL_W  = $clog2(ALLPASS_SLOT + 1);
  localparam int AM_N  = NA * ALLPASS_SLOT;
  localparam int AM_W  = $clog2(AM_N);
  localparam int PD_W  = (PREDELAY_DEPTH > 1) ? $clog2(PREDELAY_DEPTH) : 1;
  localparam int CLR_A = (CM_N > AM_N) ? CM_N : AM_N;
  localparam int CLR_N = (CLR_A > PREDELAY_DEPTH) ? CLR_A : PREDELAY_DEPTH;
  localparam int CLR_W = $clog2(CLR_N);
  localparam int ACC_W = SAMPLE_BITS + 20;
  localparam int SUM_W = SAMPLE_BITS + 3;
  localparam int RW    = crv_pkg::LEN_RAW_W;
  localparam int BW    = crv_pkg::MUL_B_W;
  localparam logic signed [ACC_W-1:0] SMAX =
    ACC_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
  localparam logic signed [ACC_W-1:0] SMIN =
    ACC_W'(-(longint'(1) <<< (SAMPLE_BITS - 1)));
  localparam logic [BW-1:0] ONE_Q16 = BW'(65536);

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SMAX) begin
      r = SMAX[SAMPLE_BITS-1:0];
    end else if (v < SMIN) begin
      r = SMIN[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic [CL_W-1:0] comb_len(input logic [RW-1:0] raw);
    logic [CL_W-1:0] l;
    if (raw == '0) begin
      l = CL_W'(1);
    end else if (int'(raw) > COMB_SLOT) begin
      l = CL_W'(COMB_SLOT);
    end else begin
      l = CL_W'(raw);
    end
    return l;
  endfunction

  function automatic logic [AL_W-1:0] ap_len(input logic [RW-1:0] raw);
    logic [AL_W-1:0] l;
    if (raw == '0) begin
      l = AL_W'(1);
    end else if (int'(raw) > ALLPASS_SLOT) begin
      l = AL_W'(ALLPASS_SLOT);
    end else begin
      l = AL_W'(raw);
    end
    return l;
  endfunction

  crv_pkg::state_e state_q, state_d;

  logic [crv_pkg::COEF_W-1:0] room_q, fb_q, damp_q, wet_q;
  logic [crv_pkg::PLEN_W-1:0] plen_q;

  logic signed [SAMPLE_BITS-1:0] x_q, delayed_q, v_q, out_q;
  logic signed [SAMPLE_BITS-1:0] lp_q [NC];
  logic signed [SUM_W-1:0]       sum_q;
  logic [CP_W-1:0]               cptr_q [NC];
  logic [AP_W-1:0]               aptr_q [NA];
  logic [PD_W-1:0]               pd_ptr_q;
  logic [2:0]                    k_q;
  logic [CL_W-1:0]               len_q;
  logic [CLR_W-1:0]              clr_cnt_q;
  logic                          out_valid_q;

  logic signed [SAMPLE_BITS-1:0] comb_mem [CM_N];
  logic signed [SAMPLE_BITS-1:0] ap_mem   [AM_N];
  logic signed [SAMPLE_BITS-1:0] pd_mem   [PREDELAY_DEPTH];
  logic signed [SAMPLE_BITS-1:0] cm_rd_q, am_rd_q, pd_rd_q;

  logic                          cm_we, am_we, pd_we, cm_re, am_re, pd_re;
  logic [CM_W-1:0]               cm_wa, cm_addr;
  logic [AM_W-1:0]               am_wa, am_addr;
  logic [PD_W-1:0]               pd_wa;
  logic signed [SAMPLE_BITS-1:0] cm_wd, am_wd, pd_wd;

  crv_pkg::mac_ctl_t             mac_ctl;
  logic signed [SAMPLE_BITS-1:0] mac_a;
  logic [BW-1:0]                 mac_b;
  logic signed [ACC_W-1:0]       acc, acc_sh;

  logic [BW-1:0]                 scale;
  logic signed [SAMPLE_BITS-1:0] lp_new, comb_wr, ap_r, ap_h, ap_wr, ap_v;
  logic [CP_W-1:0]               cptr_cur, cptr_nxt;
  logic [AP_W-1:0]               aptr_cur, aptr_nxt;
  logic [AL_W-1:0]               alen;
  logic [PD_W-1:0]               pd_nxt;
  int                            plen_eff;
  logic                          in_acc, out_load;

  assign in_ready_o   = (state_q == crv_pkg::ST_IDLE);
  assign in_acc       = in_valid_i && in_ready_o;
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;
  assign out_load     = (state_q == crv_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // Datapath helpers
  assign scale    = {1'b0, room_q} + BW'(32768);
  assign acc_sh   = acc >>> 16;
  assign lp_new   = sat(acc_sh);
  assign comb_wr  = sat(ACC_W'(delayed_q) + acc_sh);
  assign cptr_cur = cptr_q[k_q];
  assign aptr_cur = aptr_q[k_q[1:0]];
  assign cm_addr  = CM_W'(int'(k_q) * COMB_SLOT + int'(cptr_cur));
  assign am_addr  = AM_W'(int'(k_q[1:0]) * ALLPASS_SLOT + int'(aptr_cur));
  assign cptr_nxt = ((CL_W'(cptr_cur) + CL_W'(1)) >= len_q) ? '0 : cptr_cur + CP_W'(1);
  assign alen     = ap_len(acc[16 +: RW]);
  assign aptr_nxt = ((AL_W'(aptr_cur) + AL_W'(1)) >= alen) ? '0 : aptr_cur + AP_W'(1);
  assign ap_r     = am_rd_q;
  assign ap_h     = ap_r >>> 1;
  assign ap_wr    = sat(ACC_W'(v_q) - ACC_W'(ap_h));
  assign ap_v     = sat(ACC_W'(ap_r) + ((ACC_W'(v_q) + ACC_W'(ap_h)) >>> 1));

  always_comb begin
    if (plen_q == '0) begin
      plen_eff = 1;
    end else if (int'(plen_q) > PREDELAY_DEPTH) begin
      plen_eff = PREDELAY_DEPTH;
    end else begin
      plen_eff = int'(plen_q);
    end
    pd_nxt = ((int'(pd_ptr_q) + 1) >= plen_eff) ? '0 : pd_ptr_q + PD_W'(1);
  end

  // Shared unit operand selection
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state_q)
      crv_pkg::ST_C_LEN: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, rnd: 1'b0};
        mac_a   = SAMPLE_BITS'(crv_pkg::comb_base(k_q));
        mac_b   = scale;
      end
      crv_pkg::ST_C_READ: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, rnd: 1'b1};
        mac_a   = cm_rd_q;
        mac_b   = ONE_Q16 - {1'b0, damp_q};
      end
      crv_pkg::ST_C_DAMP: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, rnd: 1'b0};
        mac_a   = lp_q[k_q];
        mac_b   = {1'b0, damp_q};
      end
      crv_pkg::ST_C_FB: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, rnd: 1'b1};
        mac_a   = lp_new;
        mac_b   = {1'b0, fb_q};
      end
      crv_pkg::ST_A_LEN: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, rnd: 1'b0};
        mac_a   = SAMPLE_BITS'(crv_pkg::ap_base(k_q[1:0]));
        mac_b   = scale;
      end
      crv_pkg::ST_MIX_WET: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, rnd: 1'b1};
        mac_a   = v_q;
        mac_b   = {1'b0, wet_q};
      end
      crv_pkg::ST_MIX_DRY: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, rnd: 1'b0};
        mac_a   = x_q;
        mac_b   = ONE_Q16 - {1'b0, wet_q};
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  crv_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  // Memory port selection
  always_comb begin
    cm_we = 1'b0;
    am_we = 1'b0;
    pd_we = 1'b0;
    cm_wa = cm_addr;
    am_wa = am_addr;
    pd_wa = pd_ptr_q;
    cm_wd = comb_wr;
    am_wd = ap_wr;
    pd_wd = sample_in_i;
    cm_re = (state_q == crv_pkg::ST_C_LEN);
    am_re = (state_q == crv_pkg::ST_A_LEN);
    pd_re = in_acc;
    if (state_q == crv_pkg::ST_CLEAR) begin
      cm_we = (int'(clr_cnt_q) < CM_N);
      am_we = (int'(clr_cnt_q) < AM_N);
      pd_we = (int'(clr_cnt_q) < PREDELAY_DEPTH);
      cm_wa = CM_W'(clr_cnt_q);
      am_wa = AM_W'(clr_cnt_q);
      pd_wa = PD_W'(clr_cnt_q);
      cm_wd = '0;
      am_wd = '0;
      pd_wd = '0;
    end else begin
      cm_we = (state_q == crv_pkg::ST_C_WRITE);
      am_we = (state_q == crv_pkg::ST_A_WRITE);
      pd_we = in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      comb_mem[cm_wa] <= cm_wd;
    end
    if (am_we) begin
      ap_mem[am_wa] <= am_wd;
    end
    if (pd_we) begin
      pd_mem[pd_wa] <= pd_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cm_re) begin
      cm_rd_q <= comb_mem[cm_addr];
    end
    if (am_re) begin
      am_rd_q <= ap_mem[am_addr];
    end
    if (pd_re) begin
      pd_rd_q <= pd_mem[pd_ptr_q];
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crv_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      crv_pkg::ST_CLEAR: begin
        if (int'(clr_cnt_q) == CLR_N - 1) begin
          state_d = crv_pkg::ST_IDLE;
        end
      end
      crv_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = crv_pkg::ST_PRE;
        end
      end
      crv_pkg::ST_PRE:     state_d = crv_pkg::ST_C_LEN;
      crv_pkg::ST_C_LEN:   state_d = crv_pkg::ST_C_READ;
      crv_pkg::ST_C_READ:  state_d = crv_pkg::ST_C_DAMP;
      crv_pkg::ST_C_DAMP:  state_d = crv_pkg::ST_C_FB;
      crv_pkg::ST_C_FB:    state_d = crv_pkg::ST_C_WRITE;
      crv_pkg::ST_C_WRITE: begin
        state_d = (k_q == 3'(NC - 1)) ? crv_pkg::ST_A_LEN : crv_pkg::ST_C_LEN;
      end
      crv_pkg::ST_A_LEN:   state_d = crv_pkg::ST_A_WRITE;
      crv_pkg::ST_A_WRITE: begin
        state_d = (k_q == 3'(NA - 1)) ? crv_pkg::ST_MIX_WET : crv_pkg::ST_A_LEN;
      end
      crv_pkg::ST_MIX_WET: state_d = crv_pkg::ST_MIX_DRY;
      crv_pkg::ST_MIX_DRY: state_d = crv_pkg::ST_DONE;
      crv_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = crv_pkg::ST_IDLE;
        end
      end
      default: state_d = crv_pkg::ST_IDLE;
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q      <= crv_pkg::ROOM_RST;
      fb_q        <= crv_pkg::FB_RST;
      damp_q      <= crv_pkg::DAMP_RST;
      plen_q      <= crv_pkg::PLEN_RST;
      wet_q       <= crv_pkg::WET_RST;
      pd_ptr_q    <= '0;
      k_q         <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        cptr_q[i] <= '0;
        lp_q[i]   <= '0;
      end
      for (int i = 0; i < NA; i++) begin
        aptr_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          crv_pkg::CFG_ROOM: room_q <= cfg_data_i;
          crv_pkg::CFG_FB:   fb_q   <= cfg_data_i;
          crv_pkg::CFG_DAMP: damp_q <= cfg_data_i;
          crv_pkg::CFG_PLEN: plen_q <= cfg_data_i[crv_pkg::PLEN_W-1:0];
          crv_pkg::CFG_WET:  wet_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == crv_pkg::ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + CLR_W'(1);
      end
      if (in_acc) begin
        pd_ptr_q <= pd_nxt;
      end
      if (state_q == crv_pkg::ST_PRE) begin
        k_q <= '0;
      end
      if (state_q == crv_pkg::ST_C_FB) begin
        lp_q[k_q] <= lp_new;
      end
      if (state_q == crv_pkg::ST_C_WRITE) begin
        cptr_q[k_q] <= cptr_nxt;
        k_q         <= (k_q == 3'(NC - 1)) ? '0 : k_q + 3'd1;
      end
      if (state_q == crv_pkg::ST_A_WRITE) begin
        aptr_q[k_q[1:0]] <= aptr_nxt;
        k_q              <= (k_q == 3'(NA - 1)) ? '0 : k_q + 3'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sample payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= sample_in_i;
    end
    if (state_q == crv_pkg::ST_PRE) begin
      delayed_q <= pd_rd_q;
      sum_q     <= '0;
    end
    if (state_q == crv_pkg::ST_C_READ) begin
      sum_q <= sum_q + SUM_W'(cm_rd_q);
    end
    if (state_q == crv_pkg::ST_C_READ) begin
      len_q <= comb_len(acc[16 +: RW]);
    end
    if ((state_q == crv_pkg::ST_C_WRITE) && (k_q == 3'(NC - 1))) begin
      v_q <= SAMPLE_BITS'(sum_q >>> 3);
    end
    if (state_q == crv_pkg::ST_A_WRITE) begin
      v_q <= ap_v;
    end
    if (out_load) begin
      out_q <= sat(acc_sh);
    end
  end

endmodule
